// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared word types, result codes, character constants and decode helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Input word: one raw text byte or an end-of-text marker.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [1:0] error_code;
      logic       last;
   } rsp_word_type;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NO_QUOTE  = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;
   localparam logic [1:0] ERR_ESCAPE    = 2'd3;

   // Most results that one input word can cause.
   localparam int MAX_RESULTS = 3;

   // All results caused by one input word, held together until drained.
   typedef struct packed {
      logic [1:0]                  count;
      logic [1:0]                  kind;
      logic [1:0]                  error_code;
      logic [MAX_RESULTS-1:0][7:0] data;
   } res_bundle_type;

   // Character codes.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;
   localparam logic [7:0] CH_RETURN    = 8'h0D;

   // UTF-8 encoding limits and lead/continuation marks.
   localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
   localparam logic [2:0]  UTF8_LEAD_TWO  = 3'b110;
   localparam logic [3:0]  UTF8_LEAD_THREE = 4'b1110;
   localparam logic [1:0]  UTF8_CONT      = 2'b10;

   // True when the byte is a hex digit of either case.
   function automatic logic hex_valid(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   // Value of a hex digit; zero for anything else.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

// ===== hw/rtl/jsu_decoder.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the parser state and turns one input word into a bundle of results.
// ----------------------------------------------------------------------------
module jsu_decoder
   import jsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  req_word_type   word,
   output res_bundle_type bundle
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [15:0] acc_ff, acc_in;

   logic        is_hex;
   logic [3:0]  nibble;
   logic [15:0] code_point;
   logic        in_string_error;

   // Shared decode of the current byte.
   assign is_hex          = hex_valid(word.in_byte);
   assign nibble          = hex_value(word.in_byte);
   assign code_point      = {acc_ff[11:0], nibble};
   assign in_string_error = word.text_end || (word.in_byte == CH_NEWLINE);

   // Next parser state.
   always_comb begin
      phase_in   = phase_ff;
      hex_cnt_in = hex_cnt_ff;
      acc_in     = acc_ff;
      case (phase_ff)
         PH_OPEN: begin
            if (!word.text_end && word.in_byte == CH_QUOTE) begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (in_string_error || word.in_byte == CH_QUOTE) begin
               phase_in = PH_OPEN;
            end else if (word.in_byte == CH_BACKSLASH) begin
               phase_in = PH_ESC;
            end
         end
         PH_ESC: begin
            if (in_string_error) begin
               phase_in = PH_OPEN;
            end else begin
               case (word.in_byte)
                  CH_LOWER_B, CH_LOWER_T, CH_LOWER_N, CH_LOWER_F, CH_LOWER_R,
                  CH_QUOTE, CH_SLASH, CH_BACKSLASH: begin
                     phase_in = PH_BODY;
                  end
                  CH_LOWER_U: begin
                     phase_in   = PH_HEX;
                     hex_cnt_in = 2'd0;
                     acc_in     = 16'h0000;
                  end
                  default: begin
                     phase_in = PH_OPEN;
                  end
               endcase
            end
         end
         PH_HEX: begin
            if (in_string_error || !is_hex) begin
               phase_in   = PH_OPEN;
               hex_cnt_in = 2'd0;
               acc_in     = 16'h0000;
            end else if (hex_cnt_ff == 2'd3) begin
               phase_in   = PH_BODY;
               hex_cnt_in = 2'd0;
               acc_in     = 16'h0000;
            end else begin
               hex_cnt_in = hex_cnt_ff + 2'd1;
               acc_in     = code_point;
            end
         end
         default: begin
            phase_in = PH_OPEN;
         end
      endcase
   end

   // Results caused by the current byte.
   always_comb begin
      bundle = '0;
      case (phase_ff)
         PH_OPEN: begin
            if (word.text_end || word.in_byte != CH_QUOTE) begin
               bundle.count      = 2'd1;
               bundle.kind       = KIND_ERR;
               bundle.error_code = ERR_NO_QUOTE;
            end
         end
         PH_BODY: begin
            if (in_string_error) begin
               bundle.count      = 2'd1;
               bundle.kind       = KIND_ERR;
               bundle.error_code = ERR_UNMATCHED;
            end else if (word.in_byte == CH_QUOTE) begin
               bundle.count = 2'd1;
               bundle.kind  = KIND_DONE;
            end else if (word.in_byte != CH_BACKSLASH) begin
               bundle.count   = 2'd1;
               bundle.data[0] = word.in_byte;
            end
         end
         PH_ESC: begin
            if (in_string_error) begin
               bundle.count      = 2'd1;
               bundle.kind       = KIND_ERR;
               bundle.error_code = ERR_UNMATCHED;
            end else begin
               bundle.count = 2'd1;
               case (word.in_byte)
                  CH_LOWER_B:   bundle.data[0] = CH_BACKSPACE;
                  CH_LOWER_T:   bundle.data[0] = CH_TAB;
                  CH_LOWER_N:   bundle.data[0] = CH_NEWLINE;
                  CH_LOWER_F:   bundle.data[0] = CH_FORMFEED;
                  CH_LOWER_R:   bundle.data[0] = CH_RETURN;
                  CH_QUOTE, CH_SLASH, CH_BACKSLASH: begin
                     bundle.data[0] = word.in_byte;
                  end
                  CH_LOWER_U: begin
                     bundle.count = 2'd0;
                  end
                  default: begin
                     bundle.kind       = KIND_ERR;
                     bundle.error_code = ERR_ESCAPE;
                  end
               endcase
            end
         end
         PH_HEX: begin
            if (in_string_error) begin
               bundle.count      = 2'd1;
               bundle.kind       = KIND_ERR;
               bundle.error_code = ERR_UNMATCHED;
            end else if (!is_hex) begin
               bundle.count      = 2'd1;
               bundle.kind       = KIND_ERR;
               bundle.error_code = ERR_ESCAPE;
            end else if (hex_cnt_ff == 2'd3) begin
               // Fourth digit: encode the code point as UTF-8.
               if (code_point < UTF8_ONE_LIMIT) begin
                  bundle.count   = 2'd1;
                  bundle.data[0] = code_point[7:0];
               end else if (code_point < UTF8_TWO_LIMIT) begin
                  bundle.count   = 2'd2;
                  bundle.data[0] = {UTF8_LEAD_TWO, code_point[10:6]};
                  bundle.data[1] = {UTF8_CONT, code_point[5:0]};
               end else begin
                  bundle.count   = 2'd3;
                  bundle.data[0] = {UTF8_LEAD_THREE, code_point[15:12]};
                  bundle.data[1] = {UTF8_CONT, code_point[11:6]};
                  bundle.data[2] = {UTF8_CONT, code_point[5:0]};
               end
            end
         end
         default: begin
            bundle = '0;
         end
      endcase
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPEN;
         hex_cnt_ff <= 2'd0;
         acc_ff     <= 16'h0000;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hex_cnt_ff <= hex_cnt_in;
         acc_ff     <= acc_in;
      end
   end

   // The digit count and accumulator are only in use while reading hex digits.
   a_hex_state_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEX) |-> (hex_cnt_ff == 2'd0 && acc_ff == 16'h0000))
      else $error("hex state not clear outside hex phase");

endmodule

// ===== hw/rtl/jsu_result_buf.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Holds one bundle of results and hands them out one word per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module jsu_result_buf
   import jsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  res_bundle_type bundle,
   output logic           free,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);

   logic           valid_ff, valid_in;
   logic [1:0]     idx_ff, idx_in;
   res_bundle_type bundle_ff, bundle_in;

   logic           take;
   logic           final_word;

   // Handshake on the result side.
   assign take       = valid_ff && !rsp_stall;
   assign final_word = (idx_ff == bundle_ff.count - 2'd1);
   assign free       = !valid_ff || (take && final_word);
   assign rsp_valid  = valid_ff;

   // Present the word at the current index.
   always_comb begin
      rsp_word            = '0;
      rsp_word.kind       = bundle_ff.kind;
      rsp_word.error_code = bundle_ff.error_code;
      rsp_word.last       = final_word;
      case (idx_ff)
         2'd0:    rsp_word.out_byte = bundle_ff.data[0];
         2'd1:    rsp_word.out_byte = bundle_ff.data[1];
         2'd2:    rsp_word.out_byte = bundle_ff.data[2];
         default: rsp_word.out_byte = 8'h00;
      endcase
   end

   // Load a new bundle, step through it, or drain it.
   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (load) begin
         valid_in  = (bundle.count != 2'd0);
         idx_in    = 2'd0;
         bundle_in = bundle;
      end else if (take && final_word) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   // A held bundle always has at least one word, and the index stays inside it.
   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bundle_ff.count != 2'd0))
      else $error("result buffer holds an empty bundle");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < bundle_ff.count))
      else $error("result index past end of bundle");

   // A bundle is never overwritten before its last word is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result bundle overwritten");

endmodule

// ===== hw/rtl/json_string_unescape_top.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape top level
// Decodes a JSON string literal one text byte at a time into UTF-8 bytes,
// a completion word, or an error word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word type      Handshake
//  req_     in         req_word_type  req_valid / req_stall
//  rsp_     out        rsp_word_type  rsp_valid / rsp_stall
//
//  A word is held in the input register, then is decoded into the result
//  buffer, which offers its results one word at a time on the rsp_ side.
//  Sustained rate is one input word per cycle while rsp_stall is low; a
//  \u escape that encodes to two or three UTF-8 bytes holds the input
//  while the result buffer drains one word per cycle.
//  Reset is synchronous; the parser then expects an opening quote.
//  A stall on the result side backs up into req_stall without losing words.
//
module json_string_unescape_top
   import jsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic           in_valid_ff, in_valid_in;
   req_word_type   in_word_ff, in_word_in;
   logic           buf_free;
   logic           advance;
   res_bundle_type bundle;

   // Move the held word into the decoder when the result buffer frees up.
   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_word_in = req_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   // Parser and result decode.
   jsu_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (in_word_ff),
      .bundle  (bundle)
   );

   // Result buffer and output handshake.
   jsu_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // The input side only stalls while a word is waiting in the input register.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

endmodule
